>>> rtl/nibacc_pkg.sv
// Shared opcodes, widths and state types of the nibble opcode accumulator CPU.
package nibacc_pkg;

    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 8;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    localparam logic [3:0] OPC_NOP = 4'h0;
    localparam logic [3:0] OPC_LDA = 4'h1;
    localparam logic [3:0] OPC_ADD = 4'h2;
    localparam logic [3:0] OPC_SUB = 4'h3;
    localparam logic [3:0] OPC_STA = 4'h4;
    localparam logic [3:0] OPC_JMP = 4'h5;
    localparam logic [3:0] OPC_JMC = 4'h6;
    localparam logic [3:0] OPC_JMZ = 4'h7;
    localparam logic [3:0] OPC_OUT = 4'h8;
    localparam logic [3:0] OPC_HLT = 4'h9;
    localparam logic [3:0] OPC_LDI = 4'hA;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] outv;
        logic [ADDR_W-1:0] pc;
        logic              carry;
        logic              borrow;
    } cpu_state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } mem_wr_t;

endpackage

>>> rtl/nibacc_exec.sv
// Instruction execute unit: decodes one fetched word and forms the next CPU state.
module nibacc_exec
    import nibacc_pkg::*;
(
    input  cpu_state_t        cur,
    input  logic [DATA_W-1:0] word,
    input  logic [DATA_W-1:0] opnd,
    output cpu_state_t        nxt,
    output mem_wr_t           wr,
    output logic              halt
);

    logic [3:0]        opc;
    logic [ADDR_W-1:0] arg;
    logic [ADDR_W-1:0] pc_inc;
    logic [DATA_W:0]   sum;
    logic [DATA_W:0]   diff;

    assign opc    = word[DATA_W-1:DATA_W-4];
    assign arg    = word[ADDR_W-1:0];
    assign pc_inc = cur.pc + ADDR_W'(1);
    assign sum    = {1'b0, cur.acc} + {1'b0, opnd};
    assign diff   = {1'b0, cur.acc} - {1'b0, opnd};

    always_comb begin
        nxt     = cur;
        nxt.pc  = pc_inc;
        halt    = 1'b0;
        wr.en   = 1'b0;
        wr.addr = arg;
        wr.data = cur.acc;
        unique case (opc)
            OPC_LDA: begin
                nxt.acc = opnd;
            end
            OPC_LDI: begin
                nxt.acc = DATA_W'(arg);
            end
            OPC_ADD: begin
                nxt.acc = sum[DATA_W-1:0];
                if (sum[DATA_W]) begin
                    nxt.carry = 1'b1;
                end
            end
            OPC_SUB: begin
                nxt.acc = diff[DATA_W-1:0];
                if (diff[DATA_W]) begin
                    nxt.borrow = 1'b1;
                end
            end
            OPC_STA: begin
                wr.en = 1'b1;
            end
            OPC_JMP: begin
                nxt.pc = arg;
            end
            OPC_JMC: begin
                if (cur.carry) begin
                    nxt.pc    = arg;
                    nxt.carry = 1'b0;
                end
            end
            OPC_JMZ: begin
                if (cur.borrow) begin
                    nxt.pc     = arg;
                    nxt.borrow = 1'b0;
                end
            end
            OPC_OUT: begin
                nxt.outv = opnd;
            end
            OPC_HLT: begin
                nxt.pc = cur.pc;
                halt   = 1'b1;
            end
            default: begin
                nxt.pc = pc_inc;
            end
        endcase
    end

endmodule

>>> rtl/nibble_opcode_accumulator_cpu.sv
// Top level of the nibble opcode accumulator CPU with its register file and result register.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_func, s_load_addr, s_load_data
//   m_      | out       | m_valid / m_ready  | m_acc_value, m_out_value, m_prog_counter,
//           |           |                    | m_carry_set, m_borrow_set, m_halted
//
// One transaction is accepted per cycle while s_ready is high; its result is written
// to the result register. The fetch, the operand read of the 16-byte register file and the
// execute unit form one combinational path from the state registers to the result.
// Synchronous active-low reset clears the memory, the CPU registers and the result valid flag.
// While a result is held by m_ready low, s_ready is low; s_ready is high when the
// result register is empty or is being emptied in the same cycle.
module nibble_opcode_accumulator_cpu
    import nibacc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  logic [ADDR_W-1:0] s_load_addr,
    input  logic [DATA_W-1:0] s_load_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_acc_value,
    output logic [DATA_W-1:0] m_out_value,
    output logic [ADDR_W-1:0] m_prog_counter,
    output logic              m_carry_set,
    output logic              m_borrow_set,
    output logic              m_halted
);

    logic [DATA_W-1:0] mem_reg [MEM_DEPTH];
    cpu_state_t        state_reg;
    cpu_state_t        state_next;
    cpu_state_t        exec_state;
    mem_wr_t           exec_wr;
    logic              exec_halt;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] opnd;
    logic              fire;
    logic              step;
    logic              m_valid_reg;
    cpu_state_t        res_reg;
    logic              halt_reg;

    assign fire    = s_valid && s_ready;
    assign step    = (s_func == FUNC_STEP);
    assign s_ready = !m_valid_reg || m_ready;
    assign word    = mem_reg[state_reg.pc];
    assign opnd    = mem_reg[word[ADDR_W-1:0]];

    nibacc_exec u_exec (
        .cur  (state_reg),
        .word (word),
        .opnd (opnd),
        .nxt  (exec_state),
        .wr   (exec_wr),
        .halt (exec_halt)
    );

    assign state_next = step ? exec_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MEM_DEPTH; i++) begin
                mem_reg[i] <= '0;
            end
        end else if (fire) begin
            if (!step) begin
                mem_reg[s_load_addr] <= s_load_data;
            end else if (exec_wr.en) begin
                mem_reg[exec_wr.addr] <= exec_wr.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg  <= state_next;
            halt_reg <= step && exec_halt;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_acc_value    = res_reg.acc;
    assign m_out_value    = res_reg.outv;
    assign m_prog_counter = res_reg.pc;
    assign m_carry_set    = res_reg.carry;
    assign m_borrow_set   = res_reg.borrow;
    assign m_halted       = halt_reg;

    // The pending result always mirrors the architectural state it reports.
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_prog_counter == state_reg.pc) && (m_acc_value == state_reg.acc)
                    && (m_carry_set == state_reg.carry) && (m_borrow_set == state_reg.borrow))
        else $error("result register out of step with CPU state");

    // A load transaction never reports a halt and never moves the program counter.
    a_load_no_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !step |=> !m_halted && (state_reg.pc == $past(state_reg.pc)))
        else $error("load transaction changed execution state");

    // A halt keeps the program counter where it was.
    a_halt_holds_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && step && exec_halt |=> state_reg.pc == $past(state_reg.pc))
        else $error("halt moved the program counter");

    // An empty result register always lets a new transaction in.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule
